// ===== hw/rtl/ckts_pkg.sv =====
// Shared types and constants for the CP tensor top-k search block.
package ckts_pkg;

  localparam int MAX_TOP     = 16;
  localparam int FACTOR_BITS = 16;
  localparam int OUT_FRAC    = 45;
  localparam int VAL_BITS    = 53;
  localparam int ACC_BITS    = VAL_BITS + 1;

  localparam int AB_BITS     = 2 * FACTOR_BITS;
  localparam int C_BITS      = FACTOR_BITS + 1;
  localparam int PROD_BITS   = AB_BITS + C_BITS;
  localparam int PROD_FRAC   = 3 * (FACTOR_BITS - 1);
  localparam int SCALE_SHIFT = PROD_FRAC - OUT_FRAC;

  localparam int FILL_BITS   = $clog2(MAX_TOP + 1);

  localparam int CMD_DEPTH   = 4;
  localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;
  localparam int NF_BITS        = 2;
  localparam int TC_BITS        = 5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_FACTORS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_COUNT   = 2'd1;

  localparam logic [NF_BITS-1:0] NUM_FACTORS_RESET = 2'd2;
  localparam logic [NF_BITS-1:0] NUM_FACTORS_THREE = 2'd3;
  localparam logic [TC_BITS-1:0] TOP_COUNT_RESET   = 5'd16;

  // One finished element sum headed for the list, with the end-of-scan mark.
  typedef struct packed {
    logic signed [VAL_BITS-1:0] value;
    logic                       emit;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage

// ===== hw/rtl/ckts_front.sv =====
// Front end: factor multiply pipeline and saturating rank accumulation.
module ckts_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [ckts_pkg::FACTOR_BITS-1:0] factor_a,
  input  logic signed [ckts_pkg::FACTOR_BITS-1:0] factor_b,
  input  logic signed [ckts_pkg::FACTOR_BITS-1:0] factor_c,
  input  logic                                   term_last,
  input  logic                                   scan_last,
  input  logic [ckts_pkg::NF_BITS-1:0]           num_factors,
  input  logic                                   cmd_full,
  output logic                                   cmd_push,
  output ckts_pkg::cmd_t                         cmd
);

  logic                                   s1_valid;
  logic signed [ckts_pkg::AB_BITS-1:0]    s1_ab;
  logic signed [ckts_pkg::C_BITS-1:0]     s1_c;
  logic                                   s1_term_last;
  logic                                   s1_scan_last;

  logic                                   s2_valid;
  logic signed [ckts_pkg::PROD_BITS-1:0]  s2_prod;
  logic                                   s2_term_last;
  logic                                   s2_scan_last;

  logic signed [ckts_pkg::VAL_BITS-1:0]   term_sum;
  logic signed [ckts_pkg::ACC_BITS-1:0]   scaled;
  logic signed [ckts_pkg::ACC_BITS-1:0]   raw_sum;
  logic signed [ckts_pkg::VAL_BITS-1:0]   sat_sum;
  logic                                   ends_elem;
  logic                                   stall;

  assign ends_elem = s2_term_last | s2_scan_last;
  assign stall     = s2_valid & ends_elem & cmd_full;
  assign full      = stall;
  assign cmd_push  = s2_valid & ends_elem & ~cmd_full;

  // Bring the product to 45 fraction bits; arithmetic shift floors.
  generate
    if (ckts_pkg::SCALE_SHIFT >= 0) begin : g_shr
      logic signed [ckts_pkg::PROD_BITS-1:0] shr;
      assign shr    = s2_prod >>> ckts_pkg::SCALE_SHIFT;
      assign scaled = ckts_pkg::ACC_BITS'(shr);
    end else begin : g_shl
      localparam int LSH = -ckts_pkg::SCALE_SHIFT;
      assign scaled = ckts_pkg::ACC_BITS'(s2_prod) <<< LSH;
    end
  endgenerate

  assign raw_sum = ckts_pkg::ACC_BITS'(term_sum) + scaled;

  always_comb begin
    if (raw_sum[ckts_pkg::ACC_BITS-1] == raw_sum[ckts_pkg::ACC_BITS-2]) begin
      sat_sum = raw_sum[ckts_pkg::VAL_BITS-1:0];
    end else if (raw_sum[ckts_pkg::ACC_BITS-1]) begin
      sat_sum = {1'b1, {(ckts_pkg::VAL_BITS-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(ckts_pkg::VAL_BITS-1){1'b1}}};
    end
  end

  assign cmd.value = sat_sum;
  assign cmd.emit  = s2_scan_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      term_sum <= '0;
    end else if (!stall) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        term_sum <= ends_elem ? '0 : sat_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_ab        <= factor_a * factor_b;
      s1_c         <= (num_factors == ckts_pkg::NUM_FACTORS_THREE)
                      ? ckts_pkg::C_BITS'(factor_c)
                      : ckts_pkg::C_BITS'(1) <<< (ckts_pkg::FACTOR_BITS - 1);
      s1_term_last <= term_last;
      s1_scan_last <= scan_last;
      s2_prod      <= s1_ab * s1_c;
      s2_term_last <= s1_term_last;
      s2_scan_last <= s1_scan_last;
    end
  end

endmodule

// ===== hw/rtl/ckts_cmd_fifo.sv =====
// Short command queue between the front end and the list back end.
module ckts_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  ckts_pkg::cmd_t wr_cmd,
  output logic           cmd_full,
  input  logic           rd,
  output logic           cmd_valid,
  output ckts_pkg::cmd_t rd_cmd
);

  ckts_pkg::cmd_t                   mem [ckts_pkg::CMD_DEPTH];
  logic [ckts_pkg::CMD_PTR_BITS-1:0] wr_ptr;
  logic [ckts_pkg::CMD_PTR_BITS-1:0] rd_ptr;
  logic [ckts_pkg::CMD_CNT_BITS-1:0] count;
  logic                              do_wr;
  logic                              do_rd;

  assign cmd_full  = (count == ckts_pkg::CMD_CNT_BITS'(ckts_pkg::CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign rd_cmd    = mem[rd_ptr];
  assign do_wr     = wr & ~cmd_full;
  assign do_rd     = rd & cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == ckts_pkg::CMD_PTR_BITS'(ckts_pkg::CMD_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == ckts_pkg::CMD_PTR_BITS'(ckts_pkg::CMD_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ===== hw/rtl/ckts_back.sv =====
// Back end: parallel sorted insertion into the kept list and list emission.
module ckts_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  ckts_pkg::cmd_t                       cmd,
  output logic                                 cmd_pop,
  input  logic [ckts_pkg::TC_BITS-1:0]         top_count,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [ckts_pkg::VAL_BITS-1:0] top_value,
  output logic                                 list_last
);

  ckts_pkg::back_state_t state;
  ckts_pkg::back_state_t state_next;

  logic signed [ckts_pkg::VAL_BITS-1:0] list      [ckts_pkg::MAX_TOP];
  logic signed [ckts_pkg::VAL_BITS-1:0] list_next [ckts_pkg::MAX_TOP];
  logic [ckts_pkg::FILL_BITS-1:0]       fill;
  logic [ckts_pkg::FILL_BITS-1:0]       fill_next;
  logic                                 list_we;

  logic                                 out_valid;
  logic                                 out_valid_next;
  logic                                 out_load;

  logic [ckts_pkg::FILL_BITS-1:0]       k;
  logic [ckts_pkg::FILL_BITS-1:0]       fill_c;
  logic [ckts_pkg::MAX_TOP-1:0]         ge;
  logic [ckts_pkg::MAX_TOP-1:0]         in_k;
  logic                                 ins;

  assign empty = ~out_valid;

  // Effective list length, clamped to one and the list depth.
  always_comb begin
    if (top_count == '0) begin
      k = ckts_pkg::FILL_BITS'(1);
    end else if (int'(top_count) > ckts_pkg::MAX_TOP) begin
      k = ckts_pkg::FILL_BITS'(ckts_pkg::MAX_TOP);
    end else begin
      k = ckts_pkg::FILL_BITS'(top_count);
    end
    fill_c = (fill > k) ? k : fill;
    for (int i = 0; i < ckts_pkg::MAX_TOP; i++) begin
      ge[i]   = (ckts_pkg::FILL_BITS'(i) < fill_c) && (list[i] >= cmd.value);
      in_k[i] = (ckts_pkg::FILL_BITS'(i) < k);
    end
    ins = |(in_k & ~ge);
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    list_we        = 1'b0;
    cmd_pop        = 1'b0;
    out_load       = 1'b0;
    out_valid_next = out_valid & ~pop;
    for (int i = 0; i < ckts_pkg::MAX_TOP; i++) begin
      list_next[i] = list[i];
    end
    unique case (state)
      ckts_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          fill_next = fill_c;
          if (ins) begin
            list_we      = 1'b1;
            fill_next    = (fill_c < k) ? fill_c + 1'b1 : k;
            list_next[0] = ge[0] ? list[0] : cmd.value;
            for (int i = 1; i < ckts_pkg::MAX_TOP; i++) begin
              if (ge[i]) begin
                list_next[i] = list[i];
              end else if (ge[i-1]) begin
                list_next[i] = cmd.value;
              end else begin
                list_next[i] = list[i-1];
              end
            end
          end
          if (cmd.emit) begin
            state_next = ckts_pkg::BK_EMIT;
          end
        end
      end
      ckts_pkg::BK_EMIT: begin
        if (!out_valid || pop) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          list_we        = 1'b1;
          fill_next      = fill - 1'b1;
          for (int i = 0; i < ckts_pkg::MAX_TOP - 1; i++) begin
            list_next[i] = list[i+1];
          end
          if (fill == ckts_pkg::FILL_BITS'(1)) begin
            state_next = ckts_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = ckts_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ckts_pkg::BK_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      for (int i = 0; i < ckts_pkg::MAX_TOP; i++) begin
        list[i] <= list_next[i];
      end
    end
    if (out_load) begin
      top_value <= list[0];
      list_last <= (fill == ckts_pkg::FILL_BITS'(1));
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= ckts_pkg::MAX_TOP)
    else $error("kept list count exceeds list depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ckts_pkg::BK_EMIT) |-> (fill != '0))
    else $error("emitting from an empty list");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (rst)
    (out_load && fill == ckts_pkg::FILL_BITS'(1))
      |=> (state == ckts_pkg::BK_IDLE && fill == '0 && list_last))
    else $error("final list item did not close the emission");

  a_descending: assert property (@(posedge clk) disable iff (rst)
    (int'(fill) >= 2) |-> (list[0] >= list[1]))
    else $error("kept list out of order");

endmodule

// ===== hw/rtl/cp_tensor_top_k_search.sv =====
// Top level of the CP tensor top-k search block: ports, configuration and wiring.
//
// Each pushed item is one rank term of a tensor element. The front end
// multiplies the active factors (a*b, then by c or by 1.0 when two factors
// are selected) in two registered multiply stages, then adds the product,
// at 45 fraction bits, into a saturating per-element sum. It takes one item
// per cycle while full is low. On term_last or scan_last the finished sum
// goes into a four-entry command queue. The back end inserts one sum per
// cycle into the descending kept list with a parallel compare-and-shift
// over all entries. On scan_last it then emits the list, one item per cycle
// (limited by pop), highest value first, with list_last on the final one,
// and leaves the list empty. While a list is being emitted the back end
// takes no new sums; the queue absorbs up to four finished elements, after
// which full rises until emission ends. An element's last term passes the
// two multiply stages and the command queue before its sum is inserted;
// the first result of a scan is then loaded from the list head into top_value.
// Configuration writes are always ready; write only while the block is
// idle. num_factors of 3 selects three factors, any other value two;
// top_count is clamped to 1..16.
module cp_tensor_top_k_search (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         push,
  output logic                                         full,
  input  logic signed [ckts_pkg::FACTOR_BITS-1:0]      factor_a,
  input  logic signed [ckts_pkg::FACTOR_BITS-1:0]      factor_b,
  input  logic signed [ckts_pkg::FACTOR_BITS-1:0]      factor_c,
  input  logic                                         term_last,
  input  logic                                         scan_last,
  output logic                                         empty,
  input  logic                                         pop,
  output logic signed [ckts_pkg::VAL_BITS-1:0]         top_value,
  output logic                                         list_last,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [ckts_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
  input  logic [ckts_pkg::CFG_DATA_BITS-1:0]           cfg_data
);

  logic [ckts_pkg::NF_BITS-1:0] num_factors;
  logic [ckts_pkg::TC_BITS-1:0] top_count;

  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_valid;
  logic           cmd_pop;
  ckts_pkg::cmd_t cmd_in;
  ckts_pkg::cmd_t cmd_out;

  assign cfg_ready = 1'b1;

  // Hold register values; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_factors <= ckts_pkg::NUM_FACTORS_RESET;
      top_count   <= ckts_pkg::TOP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ckts_pkg::REG_NUM_FACTORS: num_factors <= cfg_data[ckts_pkg::NF_BITS-1:0];
        ckts_pkg::REG_TOP_COUNT:   top_count   <= cfg_data[ckts_pkg::TC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  ckts_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .factor_a    (factor_a),
    .factor_b    (factor_b),
    .factor_c    (factor_c),
    .term_last   (term_last),
    .scan_last   (scan_last),
    .num_factors (num_factors),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  ckts_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (cmd_push),
    .wr_cmd    (cmd_in),
    .cmd_full  (cmd_full),
    .rd        (cmd_pop),
    .cmd_valid (cmd_valid),
    .rd_cmd    (cmd_out)
  );

  ckts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .top_count (top_count),
    .empty     (empty),
    .pop       (pop),
    .top_value (top_value),
    .list_last (list_last)
  );

endmodule

// ===== test/cp_tensor_top_k_search_test.sv =====
// Self-checking testbench for the CP tensor top-k search block.
module cp_tensor_top_k_search_test;

  localparam int FB = ckts_pkg::FACTOR_BITS;
  localparam int VB = ckts_pkg::VAL_BITS;
  localparam int CB = ckts_pkg::CFG_DATA_BITS;
  localparam int KEEP_MAX = ckts_pkg::MAX_TOP;

  // Saturation limits of the per-element sum and 1.0 in Q1.15.
  localparam longint SUM_MAX = 64'sh000F_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam longint ONE_Q15 = 64'sd1 << (FB - 1);

  // Cycles to let a finished element reach the kept list once nothing is expected.
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_TERMS = 12;

  typedef struct {
    logic signed [VB-1:0] value;
    logic                 last;
  } kept_value_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic signed [FB-1:0] factor_a;
  logic signed [FB-1:0] factor_b;
  logic signed [FB-1:0] factor_c;
  logic term_last;
  logic scan_last;
  logic empty;
  logic pop;
  logic signed [VB-1:0] top_value;
  logic list_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [ckts_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [CB-1:0] cfg_data;

  // Mirror of the block: configuration, running element sum and kept list.
  logic [ckts_pkg::NF_BITS-1:0] nf_setting;
  logic [ckts_pkg::TC_BITS-1:0] tc_setting;
  longint element_sum;
  longint kept_vals[KEEP_MAX];
  int kept_fill;

  // List values still owed by the block, oldest first.
  kept_value_t owed_values[$];

  bit idling;
  int stall_left;
  int mismatches;
  int terms_sent;
  int scans_sent;
  int values_checked;

  cp_tensor_top_k_search u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .factor_a  (factor_a),
    .factor_b  (factor_b),
    .factor_c  (factor_c),
    .term_last (term_last),
    .scan_last (scan_last),
    .empty     (empty),
    .pop       (pop),
    .top_value (top_value),
    .list_last (list_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Fold one accepted rank term into the mirror; on the scan's end, queue the
  // kept list in descending order and clear it.
  task automatic fold_term(input logic signed [FB-1:0] a, input logic signed [FB-1:0] b,
                           input logic signed [FB-1:0] c, input logic tl, input logic sl);
    longint third;
    longint total;
    longint v;
    int k;
    int pos;
    int i;
    kept_value_t owed;
    begin
      k = int'(tc_setting);
      if (k < 1) k = 1;
      if (k > KEEP_MAX) k = KEEP_MAX;
      // An inactive third factor counts as 1.0; the product is already at 45 fraction bits.
      third = (nf_setting == ckts_pkg::NUM_FACTORS_THREE) ? longint'(c) : ONE_Q15;
      total = element_sum + longint'(a) * longint'(b) * third;
      if (total > SUM_MAX) total = SUM_MAX;
      if (total < SUM_MIN) total = SUM_MIN;
      element_sum = total;
      if (tl || sl) begin
        v = element_sum;
        element_sum = 0;
        // A shrunken count cuts the list before the insertion.
        if (kept_fill > k) kept_fill = k;
        // A full list only takes a value strictly above its smallest.
        if (!(kept_fill == k && !(v > kept_vals[k-1]))) begin
          pos = 0;
          while (pos < kept_fill && kept_vals[pos] >= v) pos++;
          i = (kept_fill < k) ? kept_fill : k - 1;
          while (i > pos) begin
            kept_vals[i] = kept_vals[i-1];
            i--;
          end
          kept_vals[pos] = v;
          if (kept_fill < k) kept_fill++;
        end
      end
      if (sl) begin
        for (i = 0; i < kept_fill; i++) begin
          owed.value = kept_vals[i][VB-1:0];
          owed.last = (i + 1 == kept_fill);
          owed_values = {owed_values, owed};
        end
        kept_fill = 0;
        element_sum = 0;
        scans_sent++;
      end
    end
  endtask

  // Push one rank term, with an occasional idle burst ahead of it.
  task automatic send_term(input logic signed [FB-1:0] a, input logic signed [FB-1:0] b,
                           input logic signed [FB-1:0] c, input logic tl, input logic sl);
    int gap;
    begin
      gap = 0;
      if (idling && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
      @(negedge clk);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      push <= 1'b1;
      factor_a <= a;
      factor_b <= b;
      factor_c <= c;
      term_last <= tl;
      scan_last <= sl;
      @(posedge clk);
      while (full) @(posedge clk);
      fold_term(a, b, c, tl, sl);
      terms_sent++;
    end
  endtask

  // Hold off until every owed value has arrived and in-flight sums have landed.
  task automatic wait_block_idle();
    begin
      @(negedge clk);
      push <= 1'b0;
      while (owed_values.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [ckts_pkg::CFG_INDEX_BITS-1:0] index,
                                input logic [CB-1:0] data);
    begin
      wait_block_idle();
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= index;
      cfg_data <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (index == ckts_pkg::REG_NUM_FACTORS) nf_setting = data[ckts_pkg::NF_BITS-1:0];
      else if (index == ckts_pkg::REG_TOP_COUNT) tc_setting = data[ckts_pkg::TC_BITS-1:0];
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  // Favor the corners of Q1.15, otherwise any value.
  function automatic logic signed [FB-1:0] pick_factor();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4: return 16'sh0001;
      default: return FB'($urandom);
    endcase
  endfunction

  // Extremes of the factor fields with two factors, one multi-term element.
  task automatic test_field_extremes();
    begin
      send_term(16'sh8000, 16'sh8000, 16'sh0000, 1'b1, 1'b0);
      send_term(16'sh7FFF, 16'sh8000, 16'sh0005, 1'b1, 1'b0);
      send_term(16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b1, 1'b0);
      send_term(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
      send_term(16'sh0000, 16'sh0000, 16'sh8000, 1'b1, 1'b0);
      send_term(16'sh0001, 16'shFFFF, 16'sh0000, 1'b0, 1'b0);
      send_term(16'sh0001, 16'sh0001, 16'sh0000, 1'b1, 1'b0);
      send_term(16'shFFFF, 16'shFFFF, 16'sh0000, 1'b1, 1'b1);
    end
  endtask

  // Only a setting of three brings in the third factor; 0, 1 and 2 select two.
  task automatic test_factor_count();
    logic [CB-1:0] settings[4];
    int n;
    begin
      settings = '{8'hFF, 8'h04, 8'h01, 8'hFE};
      for (n = 0; n < 4; n++) begin
        write_register(ckts_pkg::REG_NUM_FACTORS, settings[n]);
        send_term(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b0);
        send_term(16'sh3039, 16'shFEBF, 16'sh8000, 1'b1, 1'b0);
        send_term(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1);
      end
    end
  endtask

  // Equal values around the smallest kept one in a short full list.
  task automatic test_ties();
    logic signed [FB-1:0] scale[8];
    int n;
    begin
      write_register(ckts_pkg::REG_TOP_COUNT, 8'hE3);
      scale = '{16'sd4, 16'sd4, 16'sd8, 16'sd4, 16'sd2, 16'sd8, 16'sd4, 16'sd4};
      for (n = 0; n < 8; n++) send_term(scale[n], 16'sd256, 16'sh0000, 1'b1, n == 7);
    end
  endtask

  // Counts of zero and above the maximum clamp to one and sixteen.
  task automatic test_count_limits();
    int n;
    begin
      write_register(ckts_pkg::REG_TOP_COUNT, 8'h00);
      for (n = 0; n < 5; n++) send_term(pick_factor(), pick_factor(), pick_factor(), 1'b1, n == 4);
      write_register(ckts_pkg::REG_TOP_COUNT, 8'h1F);
      for (n = 0; n < 20; n++)
        send_term(pick_factor(), pick_factor(), pick_factor(), 1'b1, n == 19);
      write_register(ckts_pkg::REG_TOP_COUNT, 8'hF1);
      for (n = 0; n < 18; n++)
        send_term(pick_factor(), pick_factor(), pick_factor(), 1'b1, n == 17);
    end
  endtask

  // Shrink the count below the fill between elements of a scan.
  task automatic test_count_shrink();
    int n;
    begin
      write_register(ckts_pkg::REG_TOP_COUNT, 8'h10);
      for (n = 0; n < 10; n++) send_term(pick_factor(), pick_factor(), 16'sh0000, 1'b1, 1'b0);
      write_register(ckts_pkg::REG_TOP_COUNT, 8'hA4);
      send_term(pick_factor(), pick_factor(), 16'sh0000, 1'b1, 1'b1);
      write_register(ckts_pkg::REG_TOP_COUNT, 8'h10);
      for (n = 0; n < 6; n++) send_term(pick_factor(), pick_factor(), 16'sh0000, 1'b1, 1'b0);
      write_register(ckts_pkg::REG_TOP_COUNT, 8'h02);
      send_term(16'sh8000, 16'sh8000, 16'sh0000, 1'b1, 1'b0);
      send_term(pick_factor(), pick_factor(), 16'sh0000, 1'b1, 1'b1);
    end
  endtask

  // The scan's end closes an open element, including a lone one-term scan.
  task automatic test_scan_closes_element();
    begin
      write_register(ckts_pkg::REG_TOP_COUNT, 8'h05);
      send_term(16'sh1000, 16'sh2000, 16'sh0000, 1'b1, 1'b0);
      send_term(16'sh0F00, 16'sh2000, 16'sh0000, 1'b0, 1'b0);
      send_term(16'sh0F00, 16'sh2000, 16'sh0000, 1'b0, 1'b0);
      send_term(16'sh0F00, 16'sh2000, 16'sh0000, 1'b0, 1'b1);
      send_term(16'shC000, 16'sh4000, 16'sh0000, 1'b0, 1'b1);
    end
  endtask

  // Well-formed scans with random content and settings; a few odd end marks.
  task automatic test_random_scans();
    int first_term;
    int elems;
    int terms;
    int e;
    int t;
    logic tl;
    logic sl;
    begin
      first_term = terms_sent;
      while ((terms_sent - first_term < RANDOM_TERMS) || idling) begin
        write_register(ckts_pkg::REG_NUM_FACTORS, CB'($urandom_range(0, 255)));
        write_register(ckts_pkg::REG_TOP_COUNT,
                       CB'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(1, 16)));
        // Drop idling for the last scans of the random part.
        if (terms_sent - first_term >= RANDOM_TERMS / 2) idling = 1'b0;
        elems = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 8);
        for (e = 0; e < elems; e++) begin
          terms = $urandom_range(1, 2);
          for (t = 0; t < terms; t++) begin
            tl = (t == terms - 1);
            sl = (e == elems - 1) && (t == terms - 1);
            // Noise: a stray element end or a scan end with no element end.
            if ($urandom_range(0, 9) == 0) tl = 1'($urandom_range(0, 1));
            send_term(pick_factor(), pick_factor(), pick_factor(), tl, sl);
          end
        end
      end
    end
  endtask

  // Pop side: stall in bursts while idling is on, otherwise always ready.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare each accepted list value with the oldest one owed.
  always @(posedge clk) begin
    kept_value_t owed;
    if (!rst && pop && !empty) begin
      if (owed_values.size() == 0) begin
        $error("unexpected list value: top_value=%0d list_last=%0b", top_value, list_last);
        mismatches++;
      end else begin
        owed = owed_values.pop_front();
        values_checked++;
        if (top_value !== owed.value) begin
          $error("top_value: expected %0d, actual %0d", owed.value, top_value);
          mismatches++;
        end
        if (list_last !== owed.last) begin
          $error("list_last: expected %0b, actual %0b", owed.last, list_last);
          mismatches++;
        end
      end
    end
  end

  // Generous bound on the whole run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    factor_a = '0;
    factor_b = '0;
    factor_c = '0;
    term_last = 1'b0;
    scan_last = 1'b0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    nf_setting = ckts_pkg::NUM_FACTORS_RESET;
    tc_setting = ckts_pkg::TOP_COUNT_RESET;
    element_sum = 0;
    kept_fill = 0;
    idling = 1'b1;
    stall_left = 0;
    mismatches = 0;
    terms_sent = 0;
    scans_sent = 0;
    values_checked = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_factor_count();
    test_ties();
    test_count_limits();
    test_count_shrink();
    test_scan_closes_element();
    test_random_scans();
    wait_block_idle();

    $display("run: %0d rank terms over %0d scans, %0d list values checked", terms_sent,
             scans_sent, values_checked);
    $display("covered factor counts, field extremes, ties, count clamping and shrinking");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ckts_pkg.sv
hw/rtl/ckts_front.sv
hw/rtl/ckts_cmd_fifo.sv
hw/rtl/ckts_back.sv
hw/rtl/cp_tensor_top_k_search.sv
test/cp_tensor_top_k_search_test.sv
